// ----- design/rst_pkg.sv -----
`default_nettype none
package rst_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam logic [16:0] ITEM_LIMIT = 17'd65535;

    typedef enum logic [2:0] {
        CMD_SELECT    = 3'd0,
        CMD_DESELECT  = 3'd1,
        CMD_QUERY     = 3'd2,
        CMD_INSERT    = 3'd3,
        CMD_REMOVE    = 3'd4,
        CMD_CLEAR     = 3'd5,
        CMD_SET_TOTAL = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FLUSH,
        S_LOAD,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic        vld;
        logic [16:0] s;
        logic [16:0] e;
    } t_add;

    typedef struct packed {
        logic start;
        logic flush;
        t_add add;
    } t_bctl;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             over;
        logic [15:0]      sum;
    } t_bstat;

    function automatic logic [16:0] min17(input logic [16:0] a, input logic [16:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [16:0] max17(input logic [16:0] a, input logic [16:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ----- design/rst_in_if.sv -----
`default_nettype none
interface rst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] index;
    logic [15:0] count;

    modport source (output valid, output cmd, output index, output count, input ready);
    modport sink (input valid, input cmd, input index, input count, output ready);
endinterface
`default_nettype wire

// ----- design/rst_out_if.sv -----
`default_nettype none
interface rst_out_if;
    logic        valid;
    logic        ready;
    logic        is_selected;
    logic [15:0] selected_total;
    logic [15:0] item_total;
    logic        table_full;

    modport source (output valid, output is_selected, output selected_total,
                    output item_total, output table_full, input ready);
    modport sink (input valid, input is_selected, input selected_total,
                  input item_total, input table_full, output ready);
endinterface
`default_nettype wire

// ----- design/range_selection_table.sv -----
// Range selection table: one command in, one status beat out.
// Clear, set-total upward, empty select/remove and unused codes go from accept straight
// to the report state; all other commands scan the cell chain, which rotates one range
// past the merge unit at a time, then pass the tail, flush and load states before the
// report. One command is in flight; the next is taken the cycle after its beat.
// Reset (synchronous, active low) empties the table and zeroes both totals.
`default_nettype none
module range_selection_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rst_in_if.sink    i_cmd,
    rst_out_if.source o_res
);
    import rst_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [16:0]      r_a, n_a;
    logic [16:0]      r_b, n_b;
    logic [15:0]      r_nt, n_nt;
    logic [15:0]      r_tot, n_tot;
    logic [15:0]      r_selt, n_selt;
    logic [CNT_W-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_i, n_i;
    logic             r_ph, n_ph;
    logic             r_placed, n_placed;
    logic             r_sel, n_sel;
    logic             r_full, n_full;
    logic             r_ov, n_ov;
    logic             r_osel;
    logic [15:0]      r_ostot, r_oitot;
    logic             r_ofull;

    t_bctl       bctl;
    t_bstat      bstat;
    logic [15:0] ws [MAX_RANGES];
    logic [15:0] we [MAX_RANGES];
    logic [15:0] cs [MAX_RANGES];
    logic [15:0] ce [MAX_RANGES];
    logic        shift, load;

    logic [16:0] idx, cnt, sum_ic, tot17, hs, he;
    logic        act;
    t_add        xa, ya;

    genvar k;
    generate
        for (k = 0; k < MAX_RANGES; k++) begin : g_cell
            rst_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(shift),
                .i_load (load),
                .i_nb_s (cs[(k + 1) % MAX_RANGES]),
                .i_nb_e (ce[(k + 1) % MAX_RANGES]),
                .i_ld_s (ws[k]),
                .i_ld_e (we[k]),
                .o_s    (cs[k]),
                .o_e    (ce[k])
            );
        end
    endgenerate

    rst_builder u_builder (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl (bctl),
        .o_stat(bstat),
        .o_ws  (ws),
        .o_we  (we)
    );

    assign idx    = {1'b0, i_cmd.index};
    assign cnt    = {1'b0, i_cmd.count};
    assign sum_ic = idx + cnt;
    assign tot17  = {1'b0, r_tot};
    assign hs     = {1'b0, cs[0]};
    assign he     = {1'b0, ce[0]};
    assign act    = {1'b0, r_i} < r_used;

    // Per-range candidates: first and second add for the head range.
    always_comb begin
        xa = '0;
        ya = '0;
        case (r_cmd)
            CMD_SELECT: begin
                xa = '{vld: !r_placed && hs > r_a, s: r_a, e: r_b};
                ya = '{vld: 1'b1, s: hs, e: he};
            end
            CMD_DESELECT: begin
                xa = '{vld: 1'b1, s: hs, e: min17(he, r_a)};
                ya = '{vld: 1'b1, s: max17(hs, r_b), e: he};
            end
            CMD_INSERT: begin
                if (he <= r_a) begin
                    xa = '{vld: 1'b1, s: hs, e: he};
                end else if (hs >= r_a) begin
                    xa = '{vld: 1'b1, s: min17(hs + r_b, {1'b0, r_nt}),
                           e: min17(he + r_b, {1'b0, r_nt})};
                end else begin
                    xa = '{vld: 1'b1, s: hs, e: r_a};
                    ya = '{vld: 1'b1, s: min17(r_a + r_b, {1'b0, r_nt}),
                           e: min17(he + r_b, {1'b0, r_nt})};
                end
            end
            CMD_REMOVE: begin
                xa.vld = 1'b1;
                xa.s = (hs <= r_a) ? hs : (hs < r_b) ? r_a : hs - (r_b - r_a);
                xa.e = (he <= r_a) ? he : (he < r_b) ? r_a : he - (r_b - r_a);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_a      = r_a;
        n_b      = r_b;
        n_nt     = r_nt;
        n_tot    = r_tot;
        n_selt   = r_selt;
        n_used   = r_used;
        n_i      = r_i;
        n_ph     = r_ph;
        n_placed = r_placed;
        n_sel    = r_sel;
        n_full   = r_full;
        n_ov     = r_ov;
        bctl     = '0;
        shift    = 1'b0;
        load     = 1'b0;
        if (o_res.valid && o_res.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && !r_ov) begin
                    n_cmd    = t_cmd'(i_cmd.cmd);
                    n_a      = idx;
                    n_i      = '0;
                    n_ph     = 1'b0;
                    n_placed = 1'b0;
                    n_sel    = 1'b0;
                    n_full   = 1'b0;
                    n_state  = S_REPORT;
                    bctl.start = 1'b1;
                    case (t_cmd'(i_cmd.cmd))
                        CMD_SELECT: begin
                            n_b = min17(sum_ic, tot17);
                            if (idx < min17(sum_ic, tot17)) n_state = S_SCAN;
                        end
                        CMD_DESELECT: begin
                            n_b     = sum_ic;
                            n_state = S_SCAN;
                        end
                        CMD_QUERY: n_state = S_SCAN;
                        CMD_INSERT: begin
                            n_b     = cnt;
                            n_nt    = 16'(min17(max17(tot17 + cnt, sum_ic), ITEM_LIMIT));
                            n_state = S_SCAN;
                        end
                        CMD_REMOVE: begin
                            n_b = min17(sum_ic, tot17);
                            if (idx < min17(sum_ic, tot17)) n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_used = '0;
                            n_selt = '0;
                        end
                        CMD_SET_TOTAL: begin
                            if (cnt < tot17) begin
                                n_cmd   = CMD_REMOVE;
                                n_a     = cnt;
                                n_b     = tot17;
                                n_state = S_SCAN;
                            end else begin
                                n_tot = i_cmd.count;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_ph) begin
                    bctl.add     = xa;
                    bctl.add.vld = xa.vld && act;
                    if (xa.vld && act && r_cmd == CMD_SELECT) n_placed = 1'b1;
                    if (act && r_cmd == CMD_QUERY && hs <= r_a && r_a < he) n_sel = 1'b1;
                    n_ph = 1'b1;
                end else begin
                    bctl.add     = ya;
                    bctl.add.vld = ya.vld && act;
                    shift = 1'b1;
                    n_ph  = 1'b0;
                    n_i   = r_i + IDX_W'(1);
                    if (r_i == IDX_W'(MAX_RANGES - 1)) n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                bctl.add = '{vld: r_cmd == CMD_SELECT && !r_placed, s: r_a, e: r_b};
                n_state  = S_FLUSH;
            end
            S_FLUSH: begin
                bctl.flush = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (r_cmd != CMD_QUERY) begin
                    if (bstat.over) begin
                        n_full = 1'b1;
                    end else begin
                        load   = 1'b1;
                        n_used = bstat.n;
                        n_selt = bstat.sum;
                        if (r_cmd == CMD_INSERT) n_tot = r_nt;
                        if (r_cmd == CMD_REMOVE) n_tot = r_tot - 16'(r_b - r_a);
                    end
                end
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tot   <= '0;
            r_selt  <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tot   <= n_tot;
            r_selt  <= n_selt;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_nt     <= n_nt;
        r_i      <= n_i;
        r_ph     <= n_ph;
        r_placed <= n_placed;
        r_sel    <= n_sel;
        r_full   <= n_full;
        // Capture the result beat as the report state hands off.
        if (r_state == S_REPORT) begin
            r_osel  <= r_sel;
            r_ostot <= r_selt;
            r_oitot <= r_tot;
            r_ofull <= r_full;
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE) && !r_ov;
    assign o_res.valid          = r_ov;
    assign o_res.is_selected    = r_osel;
    assign o_res.selected_total = r_ostot;
    assign o_res.item_total     = r_oitot;
    assign o_res.table_full     = r_ofull;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_RANGES))
        else $error("range count exceeds table depth");

    a_sel_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_selt <= r_tot)
        else $error("selected total above item total");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_state != S_IDLE)
        else $error("accepted beat left control idle");

    a_full_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REPORT && r_full |->
            (r_cmd == CMD_SELECT || r_cmd == CMD_DESELECT || r_cmd == CMD_INSERT))
        else $error("table full flagged on a command that cannot grow the table");
endmodule
`default_nettype wire

// ----- design/rst_cell.sv -----
`default_nettype none
module rst_cell (
    input  wire logic        i_clk,
    input  wire logic        i_shift,
    input  wire logic        i_load,
    input  wire logic [15:0] i_nb_s,
    input  wire logic [15:0] i_nb_e,
    input  wire logic [15:0] i_ld_s,
    input  wire logic [15:0] i_ld_e,
    output logic      [15:0] o_s,
    output logic      [15:0] o_e
);
    logic [15:0] r_s;
    logic [15:0] r_e;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= i_ld_s;
            r_e <= i_ld_e;
        end else if (i_shift) begin
            r_s <= i_nb_s;
            r_e <= i_nb_e;
        end
    end

    assign o_s = r_s;
    assign o_e = r_e;
endmodule
`default_nettype wire

// ----- design/rst_builder.sv -----
`default_nettype none
module rst_builder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rst_pkg::t_bctl i_ctl,
    output rst_pkg::t_bstat     o_stat,
    output logic [15:0]         o_ws [rst_pkg::MAX_RANGES],
    output logic [15:0]         o_we [rst_pkg::MAX_RANGES]
);
    import rst_pkg::*;

    logic [CNT_W-1:0] r_n;
    logic             r_over;
    logic [15:0]      r_sum;
    logic [16:0]      r_ps;
    logic [16:0]      r_pe;
    logic [15:0]      r_ws [MAX_RANGES];
    logic [15:0]      r_we [MAX_RANGES];
    logic [CNT_W-1:0] nm1;
    logic [15:0]      plen;

    assign nm1  = r_n - CNT_W'(1);
    assign plen = 16'(r_pe - r_ps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_n    <= '0;
            r_over <= 1'b0;
            r_sum  <= '0;
        end else if (i_ctl.flush) begin
            if (r_n != '0) begin
                r_sum <= r_sum + plen;
            end
        end else if (i_ctl.add.vld && (i_ctl.add.e > i_ctl.add.s)) begin
            if (r_n != '0 && i_ctl.add.s <= r_pe) begin
                r_pe <= max17(r_pe, i_ctl.add.e);
            end else if (r_n == CNT_W'(MAX_RANGES)) begin
                r_over <= 1'b1;
            end else begin
                if (r_n != '0) begin
                    r_sum <= r_sum + plen;
                end
                r_ps <= i_ctl.add.s;
                r_pe <= i_ctl.add.e;
                r_n  <= r_n + CNT_W'(1);
            end
        end
    end

    // Retire the pending range into the table when a new one opens or on flush.
    always_ff @(posedge i_clk) begin
        if (r_n != '0 && (i_ctl.flush || (i_ctl.add.vld && !i_ctl.start
            && (i_ctl.add.e > i_ctl.add.s) && (i_ctl.add.s > r_pe)
            && r_n != CNT_W'(MAX_RANGES)))) begin
            r_ws[nm1[IDX_W-1:0]] <= r_ps[15:0];
            r_we[nm1[IDX_W-1:0]] <= r_pe[15:0];
        end
    end

    assign o_stat.n    = r_n;
    assign o_stat.over = r_over;
    assign o_stat.sum  = r_sum;
    assign o_ws = r_ws;
    assign o_we = r_we;
endmodule
`default_nettype wire
